// ===== sv/dcmbh_pkg.sv =====
`default_nettype none
package dcmbh_pkg;
    localparam int KeyWidth = 32;
    localparam int IndexWidth = 31;
    localparam int HashWidth = 64;
    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] MixMult = 32'd2654435761;
    localparam logic [30:0] BucketReset = 31'd1024;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharZero = 8'h30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_CRC,
        ST_MIX,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // one CRC bit step
    function automatic logic [31:0] crc_bit(input logic [31:0] crc);
        crc_bit = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    endfunction
endpackage
`default_nettype wire

// ===== sv/decimal_crc_mix_bucket_hash.sv =====
`default_nettype none
// Maps a 32-bit key to a bucket: the key is printed as signed decimal, CRC-32
// (reflected, start 0, no inversion) runs over that text, a Jenkins mix, a shift
// right by 3 and a multiply by 2654435761 follow, and the 64-bit result is reduced
// modulo bucket_count (0 gives index 0). One word at a time: in is stalled from
// acceptance until the result is taken. An item passes through acceptance, digit
// extraction (divide by ten through a reciprocal multiply, 1 to 10 digits), the
// CRC over each character (1 to 11 characters), the mix, a multiply in two halves
// over one shared 32x32 multiplier, the bit-serial remainder unit and the output;
// the CRC loop and the remainder divider set most of an item's time.
module decimal_crc_mix_bucket_hash
    import dcmbh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [KeyWidth-1:0]   lookup_key,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [IndexWidth-1:0]      bucket_index,
    input  wire logic                  cfg_we,
    input  wire logic [IndexWidth-1:0] cfg_data
);
    state_t state_reg, state_next;
    logic [IndexWidth-1:0] bucket_count_reg;
    logic [31:0] mag_reg, mag_next;
    logic [39:0] digits_reg, digits_next;
    logic [3:0] ndig_reg, ndig_next;
    logic neg_reg, neg_next;
    logic [31:0] crc_reg, crc_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] chr;
    logic [31:0] q10;
    logic [63:0] recip;
    logic [63:0] mix_val, hash_reg, hash_next;
    logic [63:0] prod_reg;
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic mix_start, mix_done, div_start, div_done;
    logic [IndexWidth-1:0] rem;
    logic [IndexWidth-1:0] idx_reg, idx_next;
    logic mul_phase_reg, mul_phase_next;
    logic in_take, out_take;

    assign in_take = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // divide by ten: floor(mag * 0xCCCCCCCD / 2^35)
    assign recip = mag_reg * 32'hCCCCCCCD;
    assign q10 = {3'd0, recip[63:35]};

    // low half of the hash first, then the high half
    assign mul_a = mul_phase_reg ? hash_reg[63:32] : hash_reg[31:0];
    assign mul_p = mul_a * MixMult;

    // character for the current CRC position: sign first, then digits MSD first
    always_comb
    begin
        if (neg_reg)
            chr = CharMinus;
        else
            chr = CharZero | {4'd0, digits_reg[39:36]};
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next = mag_reg;
        digits_next = digits_reg;
        ndig_next = ndig_reg;
        neg_next = neg_reg;
        crc_next = crc_reg;
        bit_next = bit_reg;
        hash_next = hash_reg;
        mul_phase_next = mul_phase_reg;
        idx_next = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    neg_next = lookup_key[31];
                    mag_next = lookup_key[31] ? (32'd0 - lookup_key) : lookup_key;
                    ndig_next = 4'd0;
                    crc_next = 32'd0;
                    bit_next = 3'd0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                // shift digits in at the top, the most significant ends there
                digits_next = {4'(mag_reg - ((q10 << 3) + (q10 << 1))),
                               digits_reg[39:4]};
                ndig_next = ndig_reg + 4'd1;
                mag_next = q10;
                if (q10 == 32'd0)
                    state_next = ST_CRC;
            end
            ST_CRC:
            begin
                if (bit_reg == 3'd0)
                    crc_next = crc_bit(crc_reg ^ {24'd0, chr});
                else
                    crc_next = crc_bit(crc_reg);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    if (neg_reg)
                        neg_next = 1'b0;
                    else
                    begin
                        digits_next = digits_reg << 4;
                        ndig_next = ndig_reg - 4'd1;
                        if (ndig_reg == 4'd1)
                            state_next = ST_MIX;
                    end
                end
            end
            ST_MIX:
            begin
                if (mix_done)
                begin
                    hash_next = {3'd0, mix_val[63:3]};
                    mul_phase_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // low and high halves of the 64x32 product, one a cycle
                mul_phase_next = 1'b1;
                if (mul_phase_reg)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    idx_next = rem;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_take)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mix_start = (state_reg == ST_CRC) && (bit_reg == 3'd7) && !neg_reg
                    && (ndig_reg == 4'd1);
        div_start = (state_reg == ST_MUL) && mul_phase_reg;
        in_stall = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bucket_count_reg <= BucketReset;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                bucket_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        digits_reg <= digits_next;
        ndig_reg <= ndig_next;
        neg_reg <= neg_next;
        crc_reg <= crc_next;
        bit_reg <= bit_next;
        hash_reg <= hash_next;
        mul_phase_reg <= mul_phase_next;
        idx_reg <= idx_next;
        if (state_reg == ST_MUL && !mul_phase_reg)
            prod_reg <= mul_p;
    end

    dcmbh_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .crc   (crc_next),
        .done  (mix_done),
        .value (mix_val)
    );

    dcmbh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (prod_reg + {mul_p[31:0], 32'd0}),
        .divisor   (bucket_count_reg),
        .done      (div_done),
        .remainder (rem)
    );

    assign bucket_index = idx_reg;

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(bucket_index)))
        else $error("result dropped");
    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |=> (state_reg == ST_IDLE))
        else $error("no return to idle");
`endif
endmodule
`default_nettype wire

// ===== sv/dcmbh_mix.sv =====
`default_nettype none
// Jenkins mix, one add or xor step a cycle over a shared 64-bit adder/xor.
module dcmbh_mix
    import dcmbh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [31:0]           crc,
    output logic                       done,
    output logic [HashWidth-1:0]       value
);
    logic [HashWidth-1:0] v_reg, v_next;
    logic [3:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic [HashWidth-1:0] operand;

    always_comb
    begin
        case (step_reg[2:0])
            3'd0: operand = v_reg << 12;
            3'd1: operand = v_reg >> 22;
            3'd2: operand = v_reg << 4;
            3'd3: operand = v_reg >> 9;
            3'd4: operand = v_reg << 10;
            3'd5: operand = v_reg >> 2;
            3'd6: operand = v_reg << 7;
            default: operand = v_reg >> 12;
        endcase
        v_next = v_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            v_next = {32'd0, crc};
            step_next = 4'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next = step_reg[0] ? (v_reg ^ operand) : (v_reg + operand);
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd7)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign done = busy_reg && (step_reg == 4'd7);
    assign value = v_next;
endmodule
`default_nettype wire

// ===== sv/dcmbh_div.sv =====
`default_nettype none
// Restoring 64 by 31 remainder, one quotient bit a cycle.
module dcmbh_div
    import dcmbh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [HashWidth-1:0]  dividend,
    input  wire logic [IndexWidth-1:0] divisor,
    output logic                       done,
    output logic [IndexWidth-1:0]      remainder
);
    logic [HashWidth-1:0] num_reg, num_next;
    logic [IndexWidth:0] rem_reg, rem_next;
    logic [IndexWidth-1:0] div_reg, div_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [IndexWidth+1:0] trial;

    always_comb
    begin
        trial = {rem_reg, num_reg[HashWidth-1]} - {2'b00, div_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next = dividend;
            rem_next = '0;
            div_next = divisor;
            cnt_next = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (!trial[IndexWidth+1])
                rem_next = trial[IndexWidth:0];
            else
                rem_next = {rem_reg[IndexWidth-1:0], num_reg[HashWidth-1]};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(HashWidth - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = busy_reg && (cnt_reg == 7'(HashWidth - 1));
    assign remainder = (div_reg == '0) ? '0 : rem_next[IndexWidth-1:0];
endmodule
`default_nettype wire

// ===== bench/decimal_crc_mix_bucket_hash_tb.sv =====
module decimal_crc_mix_bucket_hash_tb;
    import dcmbh_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [KeyWidth-1:0]   lookup_key;
    logic                  out_valid;
    logic                  out_stall;
    logic [IndexWidth-1:0] bucket_index;
    logic                  cfg_we;
    logic [IndexWidth-1:0] cfg_data;

    logic [KeyWidth-1:0]   pending_keys[$];
    logic [IndexWidth-1:0] expected_index[$];
    logic [IndexWidth-1:0] buckets;
    int                    errors;
    bit                    sender_idle_rand;
    bit                    receiver_idle_rand;
    int                    hold_off_cycles;
    bit                    sender_pause;

    decimal_crc_mix_bucket_hash dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .lookup_key(lookup_key),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bucket_index(bucket_index),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] ch);
        logic [31:0] c;
        c = crc ^ {24'd0, ch};
        for (int b = 0; b < 8; b++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    function automatic logic [IndexWidth-1:0] bucket_of(input logic [31:0] key,
                                                        input logic [IndexWidth-1:0] count);
        logic [31:0] crc;
        logic [31:0] mag;
        logic [7:0]  digits[10];
        logic [63:0] v;
        int          n;
        crc = 32'd0;
        n = 0;
        mag = key[31] ? (32'd0 - key) : key;
        if (key[31])
            crc = crc_update(crc, 8'h2D);
        do
        begin
            digits[n] = 8'(mag % 10);
            mag = mag / 10;
            n++;
        end
        while (mag != 0 && n < 10);
        for (int i = n - 1; i >= 0; i--)
            crc = crc_update(crc, 8'h30 + digits[i]);
        v = {32'd0, crc};
        v += v << 12;
        v ^= v >> 22;
        v += v << 4;
        v ^= v >> 9;
        v += v << 10;
        v ^= v >> 2;
        v += v << 7;
        v ^= v >> 12;
        v = (v >> 3) * 64'd2654435761;
        if (count == 0)
            return '0;
        return IndexWidth'(v % {33'd0, count});
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            lookup_key <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_index.push_back(bucket_of(lookup_key, buckets));
                void'(pending_keys.pop_front());
            end
            if (in_valid && in_stall)
                ;
            else if (!sender_pause && pending_keys.size() > 0 &&
                     !(sender_idle_rand && $urandom_range(99) < 38))
            begin
                in_valid <= 1'b1;
                lookup_key <= pending_keys[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_index.size() == 0)
                begin
                    $error("unexpected word: bucket_index %0d", bucket_index);
                    errors++;
                end
                else
                begin
                    if (bucket_index !== expected_index[0])
                    begin
                        $error("bucket_index expected %0d actual %0d",
                               expected_index[0], bucket_index);
                        errors++;
                    end
                    void'(expected_index.pop_front());
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= receiver_idle_rand && ($urandom_range(99) < 38);
        end
    end

    task automatic drain;
        while (pending_keys.size() != 0 || in_valid || expected_index.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_buckets(input logic [IndexWidth-1:0] value);
        drain();
        cfg_data <= value;
        cfg_we <= 1'b1;
        buckets = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_keys(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: pending_keys.push_back($urandom_range(999));
                1: pending_keys.push_back(32'd0 - $urandom_range(999));
                default: pending_keys.push_back($urandom);
            endcase
        end
    endtask

    initial
    begin
        logic [IndexWidth-1:0] settings[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        errors = 0;
        buckets = BucketReset;
        sender_idle_rand = 1'b1;
        receiver_idle_rand = 1'b1;
        hold_off_cycles = 0;
        sender_pause = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, signs, digit counts
        foreach (settings[i]) ;
        pending_keys.push_back(32'd0);
        pending_keys.push_back(32'd1);
        pending_keys.push_back(32'd9);
        pending_keys.push_back(32'd10);
        pending_keys.push_back(32'd999999999);
        pending_keys.push_back(32'd1000000000);
        pending_keys.push_back(32'h7FFFFFFF);
        pending_keys.push_back(32'h80000000);
        pending_keys.push_back(32'h80000001);
        pending_keys.push_back(32'hFFFFFFFF);
        pending_keys.push_back(32'hFFFFFFF6);
        pending_keys.push_back(32'hAAAAAAAA);
        pending_keys.push_back(32'h55555555);
        drain();

        // pile up behind a stalled output, then pause the sender while keys wait
        hold_off_cycles = 600;
        random_keys(4);
        drain();
        sender_pause = 1'b1;
        random_keys(3);
        repeat (50) @(posedge clk);
        sender_pause = 1'b0;
        drain();

        settings[0] = 31'd0;
        settings[1] = 31'd1;
        settings[2] = 31'h7FFFFFFF;
        settings[3] = 31'd7;
        settings[4] = 31'h55555555;
        settings[5] = 31'd1000;
        foreach (settings[s])
        begin
            set_buckets(settings[s]);
            pending_keys.push_back(32'h80000000);
            random_keys(20);
        end
        set_buckets(31'($urandom));
        random_keys(60);
        drain();
        // no random idling for a while
        sender_idle_rand = 1'b0;
        receiver_idle_rand = 1'b0;
        random_keys(80);
        drain();
        sender_idle_rand = 1'b1;
        receiver_idle_rand = 1'b1;
        set_buckets(31'd1024);
        random_keys(120);
        drain();

        if (errors == 0)
            $display("decimal_crc_mix_bucket_hash: match");
        else
            $display("decimal_crc_mix_bucket_hash: mismatch");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("decimal_crc_mix_bucket_hash: mismatch");
        $finish;
    end
endmodule
